>>> rtl/core/fmv_pkg.sv
// ----------------------------------------------------------------------------
// fmv_pkg
// Types, constants and table builders of the two-operator FM voice engine.
// ----------------------------------------------------------------------------
package fmv_pkg;

	// Fixed number formats.
	localparam int PHASE_BITS  = 24;
	localparam int SINE_SIZE   = 1024;
	localparam int SINE_IDX_W  = 10;
	localparam int QUARTER     = 256;
	localparam int QUARTER_W   = 8;
	localparam int SAMPLE_RATE = 48000;
	localparam int NOTE_COUNT  = 128;
	localparam int SINE_W      = 15;
	localparam int NOTE_W      = 7;
	localparam int VEL_W       = 7;
	localparam int ENV_W       = 24;
	localparam int RATIO_W     = 16;
	localparam int SAMPLE_W    = 24;
	localparam int CMD_W       = 2;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int OFF_SHIFT   = 28 - PHASE_BITS;

	// Scaling of one voice: c = round(num / (1270 * 2^19)).
	localparam logic [48:0] ROUND_HALF  = 49'd332922880;
	localparam int          NORM_SHIFT  = 19;
	localparam int          NORM_W      = 29;
	localparam logic [29:0] RECIP       = 30'd865757187;
	localparam int          RECIP_SHIFT = 40;
	localparam int          QUOT_W      = 19;
	localparam logic [29:0] DIVISOR     = 30'd1270;
	localparam int          ACC_W       = 32;

	localparam logic [ENV_W-1:0] ENV_FULL = '1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_MOD_RATIO    = 2'd0;
	localparam logic [1:0] REG_MOD_DEPTH    = 2'd1;
	localparam logic [1:0] REG_ATTACK_STEP  = 2'd2;
	localparam logic [1:0] REG_RELEASE_STEP = 2'd3;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SEMITONE_Q30 [12] = '{
		64'd1073741824, 64'd1137589836, 64'd1205234447, 64'd1276901417,
		64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
		64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
	};

	typedef enum logic [1:0] {
		ENV_OFF     = 2'd0,
		ENV_ATTACK  = 2'd1,
		ENV_SUSTAIN = 2'd2,
		ENV_RELEASE = 2'd3
	} env_stage_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_CHECK,
		CS_ENV,
		CS_OFFSET,
		CS_ADVANCE,
		CS_LEVEL,
		CS_RECIP,
		CS_CORRECT,
		CS_ACCUM,
		CS_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_CLEAR,
		OP_ENV,
		OP_OFFSET,
		OP_ADVANCE,
		OP_LEVEL,
		OP_RECIP,
		OP_CORRECT,
		OP_ACCUM,
		OP_LOAD
	} dp_op_t;

	typedef struct packed {
		logic [RATIO_W-1:0] mod_ratio;
		logic [RATIO_W-1:0] mod_depth;
		logic [ENV_W-1:0]   attack_step;
		logic [ENV_W-1:0]   release_step;
	} cfg_t;

	// Quarter-wave sine entry k (0..QUARTER), Q0.15 magnitude, from a Taylor series in Q30.
	function automatic logic [SINE_W-1:0] quarter_sine(int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		x    = (HALF_PI_Q30 * longint'(4 * k) + SINE_SIZE / 2) / SINE_SIZE;
		x2   = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 110;
		sum  = sum - term;
		v = (sum + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[SINE_W-1:0];
	endfunction

	// Phase increment of MIDI note n at the sample rate.
	function automatic logic [PHASE_BITS-1:0] note_increment(int n);
		longint unsigned base;
		longint unsigned inc;
		int e;
		int oct;
		int sh;
		e    = n + 3;
		oct  = e / 12 - 6;
		base = 64'd440 * SEMITONE_Q30[e % 12];
		sh   = PHASE_BITS + oct - 30;
		if (sh >= 0) begin
			inc = ((base << sh) + SAMPLE_RATE / 2) / SAMPLE_RATE;
		end else begin
			inc = ((base + (longint'(SAMPLE_RATE) << (-sh - 1))) >> (-sh)) / SAMPLE_RATE;
		end
		return inc[PHASE_BITS-1:0];
	endfunction

endpackage

>>> rtl/core/fmv_cfg.sv
// ----------------------------------------------------------------------------
// fmv_cfg
// APB register file holding the modulation and envelope settings.
// ----------------------------------------------------------------------------
module fmv_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fmv_pkg::ADDR_W-1:0] paddr,
	input  logic [fmv_pkg::DATA_W-1:0] pwdata,
	output logic [fmv_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output fmv_pkg::cfg_t              cfg
);
	import fmv_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mod_ratio    <= 16'd16384;
			cfg_q.mod_depth    <= 16'd19661;
			cfg_q.attack_step  <= 24'd58254;
			cfg_q.release_step <= 24'd573;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MOD_RATIO:    cfg_q.mod_ratio    <= pwdata[RATIO_W-1:0];
				REG_MOD_DEPTH:    cfg_q.mod_depth    <= pwdata[RATIO_W-1:0];
				REG_ATTACK_STEP:  cfg_q.attack_step  <= pwdata[ENV_W-1:0];
				REG_RELEASE_STEP: cfg_q.release_step <= pwdata[ENV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MOD_RATIO:    prdata = {16'b0, cfg_q.mod_ratio};
			REG_MOD_DEPTH:    prdata = {16'b0, cfg_q.mod_depth};
			REG_ATTACK_STEP:  prdata = {8'b0, cfg_q.attack_step};
			REG_RELEASE_STEP: prdata = {8'b0, cfg_q.release_step};
			default:          prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/fmv_dp.sv
// ----------------------------------------------------------------------------
// fmv_dp
// Voice state, sine and note tables, shared multiplier and sample mixer.
// ----------------------------------------------------------------------------
module fmv_dp #(
	parameter int NUM_VOICES = 8,
	parameter int VW         = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fmv_pkg::cfg_t                cfg,
	input  fmv_pkg::dp_op_t              op,
	input  logic [VW-1:0]                voice,
	input  logic [fmv_pkg::NOTE_W-1:0]   note_number,
	input  logic [fmv_pkg::VEL_W-1:0]    note_velocity,
	output logic                         voice_active,
	output logic [fmv_pkg::SAMPLE_W-1:0] audio_sample
);
	import fmv_pkg::*;

	env_stage_t            stage_q  [NUM_VOICES];
	logic [NOTE_W-1:0]     note_q   [NUM_VOICES];
	logic [VEL_W-1:0]      vel_q    [NUM_VOICES];
	logic [PHASE_BITS-1:0] cphase_q [NUM_VOICES];
	logic [PHASE_BITS-1:0] mphase_q [NUM_VOICES];
	logic [ENV_W-1:0]      level_q  [NUM_VOICES];

	logic [SINE_W-1:0]     quarter_rom [QUARTER+1];
	logic [PHASE_BITS-1:0] inc_rom     [NOTE_COUNT];

	for (genvar k = 0; k <= QUARTER; k++) begin : g_quarter
		localparam logic [SINE_W-1:0] VAL = quarter_sine(k);
		assign quarter_rom[k] = VAL;
	end

	for (genvar n = 0; n < NOTE_COUNT; n++) begin : g_inc
		localparam logic [PHASE_BITS-1:0] VAL = note_increment(n);
		assign inc_rom[n] = VAL;
	end

	// Folds a phase onto the quarter-wave table.
	function automatic logic [QUARTER_W:0] quarter_index(logic [PHASE_BITS-1:0] ph);
		logic [SINE_IDX_W-1:0] idx;
		idx = ph[PHASE_BITS-1 -: SINE_IDX_W];
		if (idx[QUARTER_W]) begin
			return (QUARTER_W+1)'(QUARTER) - {1'b0, idx[QUARTER_W-1:0]};
		end
		return {1'b0, idx[QUARTER_W-1:0]};
	endfunction

	env_stage_t            cur_stage;
	logic [NOTE_W-1:0]     cur_note;
	logic [VEL_W-1:0]      cur_vel;
	logic [PHASE_BITS-1:0] cur_cphase;
	logic [PHASE_BITS-1:0] cur_mphase;
	logic [ENV_W-1:0]      cur_level;
	logic [PHASE_BITS-1:0] cur_inc;

	assign cur_stage    = stage_q[voice];
	assign cur_note     = note_q[voice];
	assign cur_vel      = vel_q[voice];
	assign cur_cphase   = cphase_q[voice];
	assign cur_mphase   = mphase_q[voice];
	assign cur_level    = level_q[voice];
	assign cur_inc      = inc_rom[cur_note];
	assign voice_active = cur_stage != ENV_OFF;

	// Envelope step.
	logic [ENV_W:0]   lvl_sum;
	logic [ENV_W-1:0] new_level;
	env_stage_t       new_stage;

	assign lvl_sum = {1'b0, cur_level} + {1'b0, cfg.attack_step};

	always_comb begin
		new_level = cur_level;
		new_stage = cur_stage;
		case (cur_stage)
			ENV_ATTACK: begin
				if (lvl_sum >= {1'b0, ENV_FULL}) begin
					new_level = ENV_FULL;
					new_stage = ENV_SUSTAIN;
				end else begin
					new_level = lvl_sum[ENV_W-1:0];
				end
			end
			ENV_RELEASE: begin
				if (cfg.release_step >= cur_level) begin
					new_level = '0;
					new_stage = ENV_OFF;
				end else begin
					new_level = cur_level - cfg.release_step;
				end
			end
			default: ;
		endcase
	end

	logic [63:0]           prod_q;
	logic                  s2_neg_q;
	logic [SINE_W-1:0]     s1_mag_q;
	logic                  s1_neg_q;
	logic [NORM_W-1:0]     norm_q;
	logic [QUOT_W:0]       contrib_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [SAMPLE_W-1:0]   sample_q;

	// Modulator sine, offset and carrier sine.
	logic [SINE_W-1:0]     s2_mag;
	logic [31:0]           off_sum;
	logic [PHASE_BITS-1:0] offset;
	logic [PHASE_BITS-1:0] carrier_arg;
	logic [SINE_W-1:0]     s1_mag;

	assign s2_mag      = quarter_rom[quarter_index(cur_mphase)];
	assign off_sum     = {1'b0, prod_q[30:0]} + (32'd1 << (OFF_SHIFT - 1));
	assign offset      = off_sum[OFF_SHIFT +: PHASE_BITS];
	assign carrier_arg = s2_neg_q ? cur_cphase - offset : cur_cphase + offset;
	assign s1_mag      = quarter_rom[quarter_index(carrier_arg)];

	logic [19:0]           ratio_term;
	logic [43:0]           inc_sum;
	logic [PHASE_BITS-1:0] inc_mod;
	logic [VEL_W+1:0]      vel3;
	logic [48:0]           norm_sum;
	logic [QUOT_W-1:0]     quot;
	logic [29:0]           remainder;

	// The modulator increment is rounded to nearest before the shift.
	assign ratio_term = 20'h10000 + {4'b0, cfg.mod_ratio} * 20'd15;
	assign inc_sum    = prod_q[43:0] + 44'h10000;
	assign inc_mod    = inc_sum[17 +: PHASE_BITS];
	assign vel3       = {2'b0, cur_vel} + {1'b0, cur_vel, 1'b0};
	assign norm_sum   = {1'b0, prod_q[47:0]} + ROUND_HALF;
	assign quot       = prod_q[RECIP_SHIFT +: QUOT_W];
	assign remainder  = {1'b0, norm_q} - ({11'b0, quot} * DIVISOR);

	// One shared multiplier, fed according to the step of the current voice.
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        mul_en;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (op)
			OP_ENV: begin
				mul_a = {17'b0, s2_mag};
				mul_b = {16'b0, cfg.mod_depth};
			end
			OP_OFFSET: begin
				mul_a = {8'b0, cur_inc};
				mul_b = {12'b0, ratio_term};
			end
			OP_ADVANCE: begin
				mul_a = {17'b0, s1_mag_q};
				mul_b = {23'b0, vel3};
			end
			OP_LEVEL: begin
				mul_a = {8'b0, prod_q[23:0]};
				mul_b = {8'b0, cur_level};
			end
			OP_RECIP: begin
				mul_a = {3'b0, norm_sum[NORM_SHIFT +: NORM_W]};
				mul_b = {2'b0, RECIP};
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (op)
			OP_ENV: s2_neg_q <= cur_mphase[PHASE_BITS-1];
			OP_OFFSET: begin
				s1_mag_q <= s1_mag;
				s1_neg_q <= carrier_arg[PHASE_BITS-1];
			end
			OP_RECIP:   norm_q    <= norm_sum[NORM_SHIFT +: NORM_W];
			OP_CORRECT: contrib_q <= {1'b0, quot} + (QUOT_W+1)'(remainder >= DIVISOR);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (op == OP_CLEAR) begin
			acc_q <= '0;
		end else if (op == OP_ACCUM) begin
			if (s1_neg_q) begin
				acc_q <= acc_q - ACC_W'(contrib_q);
			end else begin
				acc_q <= acc_q + ACC_W'(contrib_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			if (acc_q > 32'sd8388607) begin
				sample_q <= 24'h7FFFFF;
			end else if (acc_q < -32'sd8388608) begin
				sample_q <= 24'h800000;
			end else begin
				sample_q <= acc_q[SAMPLE_W-1:0];
			end
		end
	end

	assign audio_sample = sample_q;

	// Note on takes the lowest idle voice, or voice 0 when all are busy.
	logic [VW-1:0] free_slot;

	always_comb begin
		free_slot = '0;
		for (int v = NUM_VOICES - 1; v >= 0; v--) begin
			if (stage_q[v] == ENV_OFF) begin
				free_slot = VW'(v);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				stage_q[v] <= ENV_OFF;
			end
		end else begin
			case (op)
				OP_NOTE_ON: stage_q[free_slot] <= ENV_ATTACK;
				OP_NOTE_OFF: begin
					for (int v = 0; v < NUM_VOICES; v++) begin
						if ((stage_q[v] == ENV_ATTACK || stage_q[v] == ENV_SUSTAIN)
						    && note_q[v] == note_number) begin
							stage_q[v] <= ENV_RELEASE;
						end
					end
				end
				OP_ENV: stage_q[voice] <= new_stage;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_NOTE_ON: begin
				note_q[free_slot]   <= note_number;
				vel_q[free_slot]    <= note_velocity;
				cphase_q[free_slot] <= '0;
				mphase_q[free_slot] <= '0;
				level_q[free_slot]  <= '0;
			end
			OP_ENV: level_q[voice] <= new_level;
			OP_ADVANCE: begin
				cphase_q[voice] <= cur_cphase + cur_inc;
				mphase_q[voice] <= cur_mphase + inc_mod;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/core/fmv_ctrl.sv
// ----------------------------------------------------------------------------
// fmv_ctrl
// Sequencer that walks the voices through the datapath steps of a tick.
// ----------------------------------------------------------------------------
module fmv_ctrl #(
	parameter int NUM_VOICES = 8,
	parameter int VW         = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [fmv_pkg::CMD_W-1:0] command,
	output logic                      sample_valid,
	input  logic                      sample_stall,
	input  logic                      voice_active,
	output fmv_pkg::dp_op_t           op,
	output logic [VW-1:0]             voice
);
	import fmv_pkg::*;

	ctrl_state_t   state_q;
	ctrl_state_t   state_nxt;
	logic [VW-1:0] voice_q;
	logic          sample_valid_q;
	logic          voice_clr;
	logic          voice_inc;
	logic          voice_last;

	assign voice_last   = voice_q == VW'(NUM_VOICES - 1);
	assign item_stall   = state_q != CS_IDLE;
	assign sample_valid = sample_valid_q;
	assign voice        = voice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= CS_IDLE;
			voice_q        <= '0;
			sample_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (voice_clr) begin
				voice_q <= '0;
			end else if (voice_inc) begin
				voice_q <= voice_q + 1'b1;
			end
			if (op == OP_LOAD) begin
				sample_valid_q <= 1'b1;
			end else if (!sample_stall) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		voice_clr = 1'b0;
		voice_inc = 1'b0;
		case (state_q)
			CS_IDLE: begin
				if (item_valid) begin
					case (command)
						CMD_TICK: begin
							op        = OP_CLEAR;
							voice_clr = 1'b1;
							state_nxt = CS_CHECK;
						end
						CMD_NOTE_ON:  op = OP_NOTE_ON;
						CMD_NOTE_OFF: op = OP_NOTE_OFF;
						default: ;
					endcase
				end
			end
			CS_CHECK: begin
				if (voice_active) begin
					state_nxt = CS_ENV;
				end else if (voice_last) begin
					state_nxt = CS_DONE;
				end else begin
					voice_inc = 1'b1;
				end
			end
			CS_ENV: begin
				op        = OP_ENV;
				state_nxt = CS_OFFSET;
			end
			CS_OFFSET: begin
				op        = OP_OFFSET;
				state_nxt = CS_ADVANCE;
			end
			CS_ADVANCE: begin
				op        = OP_ADVANCE;
				state_nxt = CS_LEVEL;
			end
			CS_LEVEL: begin
				op        = OP_LEVEL;
				state_nxt = CS_RECIP;
			end
			CS_RECIP: begin
				op        = OP_RECIP;
				state_nxt = CS_CORRECT;
			end
			CS_CORRECT: begin
				op        = OP_CORRECT;
				state_nxt = CS_ACCUM;
			end
			CS_ACCUM: begin
				op = OP_ACCUM;
				if (voice_last) begin
					state_nxt = CS_DONE;
				end else begin
					voice_inc = 1'b1;
					state_nxt = CS_CHECK;
				end
			end
			CS_DONE: begin
				// The finished sample waits here while the previous one is still held.
				if (!sample_valid_q || !sample_stall) begin
					op        = OP_LOAD;
					state_nxt = CS_IDLE;
				end
			end
			default: state_nxt = CS_IDLE;
		endcase
	end

	a_voice_range: assert property (@(posedge clk) disable iff (!arst_n)
		voice_q <= VW'(NUM_VOICES - 1))
		else $error("voice counter beyond last voice");

	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && command == CMD_TICK |=> state_q == CS_CHECK && voice_q == '0)
		else $error("tick did not start at voice zero");

	a_voice_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_ACCUM && !voice_last
		|=> state_q == CS_CHECK && voice_q == VW'($past(voice_q) + 1'b1))
		else $error("voice walk skipped a voice");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_DONE && !sample_stall |=> sample_valid && state_q == CS_IDLE)
		else $error("finished sample not presented");

endmodule

>>> rtl/core/polyphonic_two_operator_fm_voice_engine_top.sv
// ----------------------------------------------------------------------------
// polyphonic_two_operator_fm_voice_engine_top
// Eight-voice two-operator FM synthesizer producing one mono sample per tick.
// ----------------------------------------------------------------------------
// The input channel (item_valid, item_stall) carries command, note_number and
// note_velocity. A note on or note off item is applied in the cycle it is taken.
// A tick item walks the voices one at a time through one shared multiplier,
// from a clear to an output load: an idle voice passes only the check state, a
// sounding voice each state from check to accumulate. The input stalls for the
// whole walk; the next item is taken right after. The output channel
// (sample_valid, sample_stall) holds one sample register. A new tick is taken
// while a sample still waits; it then holds at its end until the earlier sample
// has been taken. Settings go through the APB port (mod_ratio at 0x0, mod_depth
// at 0x4, attack_step at 0x8, release_step at 0xC), written only while the
// block is idle, a user rule the block does not enforce. Reset puts every voice
// off, restores the default settings and empties the output register.
// ----------------------------------------------------------------------------
module polyphonic_two_operator_fm_voice_engine_top #(
	parameter int NUM_VOICES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [fmv_pkg::CMD_W-1:0]    command,
	input  logic [fmv_pkg::NOTE_W-1:0]   note_number,
	input  logic [fmv_pkg::VEL_W-1:0]    note_velocity,
	output logic                         sample_valid,
	input  logic                         sample_stall,
	output logic signed [fmv_pkg::SAMPLE_W-1:0] audio_sample,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fmv_pkg::ADDR_W-1:0]   paddr,
	input  logic [fmv_pkg::DATA_W-1:0]   pwdata,
	output logic [fmv_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import fmv_pkg::*;

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	cfg_t                cfg;
	dp_op_t              op;
	logic [VW-1:0]       voice;
	logic                voice_active;
	logic [SAMPLE_W-1:0] sample;

	fmv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fmv_ctrl #(
		.NUM_VOICES (NUM_VOICES),
		.VW         (VW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.voice_active (voice_active),
		.op           (op),
		.voice        (voice)
	);

	fmv_dp #(
		.NUM_VOICES (NUM_VOICES),
		.VW         (VW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.op            (op),
		.voice         (voice),
		.note_number   (note_number),
		.note_velocity (note_velocity),
		.voice_active  (voice_active),
		.audio_sample  (sample)
	);

	assign audio_sample = $signed(sample);

endmodule
